// File: rtl/bpnr_pkg.sv
`default_nettype none

package bpnr_pkg;

    // Word format
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_BITS = 2 * WORD_BITS;
    // Divider: quotient and partial remainder widths
    localparam int QUO_BITS  = WORD_BITS + 1;
    localparam int REM_BITS  = 2 * WORD_BITS + 1;
    localparam int CFG_BITS  = 32;
    localparam int REG_BITS  = 31;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [2:0][WORD_BITS-1:0]   vec_t;

    localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [63:0] WMAX_U = (64'd1 << (WORD_BITS-1)) - 64'd1;
    localparam word_t ONE = word_t'(64'd1 << FRAC_BITS);
    localparam logic [QUO_BITS-1:0] QUO_HALF = QUO_BITS'(1) << (WORD_BITS-1);
    localparam logic [QUO_BITS-1:0] QUO_WMAX = QUO_BITS'(WMAX_U);

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_INV_MASS  = 3'd0,
        CFG_MASS      = 3'd1,
        CFG_HALF_STEP = 3'd2,
        CFG_STEP      = 3'd3,
        CFG_DIMS      = 3'd4
    } cfg_idx_t;

    localparam logic [REG_BITS-1:0] RST_INV_MASS  = REG_BITS'(65536);
    localparam logic [REG_BITS-1:0] RST_MASS      = REG_BITS'(65536);
    localparam logic [REG_BITS-1:0] RST_HALF_STEP = '0;
    localparam logic [REG_BITS-1:0] RST_STEP      = '0;
    localparam logic [1:0]          RST_DIMS      = 2'd3;

    typedef struct packed {
        logic signed [7:0] particle_charge;
        word_t mom_x;
        word_t mom_y;
        word_t mom_z;
        word_t efield_x;
        word_t efield_y;
        word_t efield_z;
        word_t bfield_x;
        word_t bfield_y;
        word_t bfield_z;
    } in_t;

    typedef struct packed {
        word_t new_mom_x;
        word_t new_mom_y;
        word_t new_mom_z;
        word_t pos_step_x;
        word_t pos_step_y;
        word_t pos_step_z;
    } out_t;

    // Values that ride alongside the divider
    typedef struct packed {
        vec_t um;
        vec_t ur;
        vec_t ae;
    } side_t;

    // One lane of the restoring divider
    typedef struct packed {
        logic [REM_BITS-1:0] rem;
        logic [QUO_BITS-1:0] quo;
        logic                neg;
    } dlane_t;

    typedef dlane_t [2:0] dvec_t;

    // Saturate a product-width value to the word range
    function automatic word_t sat_p(input logic signed [PROD_BITS-1:0] x);
        if (x > PROD_BITS'(WMAX))
            return WMAX;
        if (x < PROD_BITS'(WMIN))
            return WMIN;
        return x[WORD_BITS-1:0];
    endfunction

    // Exact product, floor shift by FRAC_BITS, saturate
    function automatic word_t smul(input word_t a, input word_t b);
        logic signed [PROD_BITS-1:0] p;
        p = a * b;
        return sat_p(p >>> FRAC_BITS);
    endfunction

    // Product with no shift (integer charge times Q)
    function automatic word_t smul_int(input word_t a, input word_t b);
        logic signed [PROD_BITS-1:0] p;
        p = a * b;
        return sat_p(p);
    endfunction

    function automatic word_t sadd(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] s;
        s = a + b;
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WMIN : WMAX;
        return s[WORD_BITS-1:0];
    endfunction

    function automatic word_t ssub(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] s;
        s = a - b;
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WMIN : WMAX;
        return s[WORD_BITS-1:0];
    endfunction

    // Register value clamped to the word maximum
    function automatic word_t reg_word(input logic [REG_BITS-1:0] r);
        if (64'(r) > WMAX_U)
            return WMAX;
        return word_t'(r);
    endfunction

    // Sign and magnitude of the quotient back to a saturated word
    function automatic word_t div_fix(input logic neg, input logic [QUO_BITS-1:0] q);
        logic [QUO_BITS-1:0] nq;
        nq = ~q + QUO_BITS'(1);
        if (q == '0)
            return '0;
        if (neg)
            return (q > QUO_HALF) ? WMIN : word_t'(nq[WORD_BITS-1:0]);
        return (q > QUO_WMAX) ? WMAX : word_t'(q[WORD_BITS-1:0]);
    endfunction

endpackage

`default_nettype wire

// File: rtl/boris_particle_push_nonrelativistic_top.sv
`default_nettype none

// Channel  | Signals                            | Transaction when
// ---------+------------------------------------+-----------------------------
// in       | in_valid, in_stall, in_data        | in_valid & !in_stall
// out      | out_valid, out_stall, out_data     | out_valid & !out_stall
// cfg      | cfg_valid, cfg_ready, cfg_index,   | cfg_valid & cfg_ready
//          | cfg_data                           |
//
// One particle per cycle while the output is not stalled; each result passes through
// 5 front stages, WORD_BITS+3 divider stages for S and 4 back stages.
// The divider sets the depth: one quotient bit per stage.
// Reset clears all valid bits and loads the register defaults.
// A stalled valid output freezes the whole pipeline and raises in_stall.
module boris_particle_push_nonrelativistic_top
    import bpnr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire in_t                 in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output out_t                     out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [CFG_BITS-1:0] cfg_data
);

    logic [REG_BITS-1:0] inv_mass_reg;
    logic [REG_BITS-1:0] mass_reg;
    logic [REG_BITS-1:0] half_step_reg;
    logic [REG_BITS-1:0] step_reg;
    logic [1:0]          dims_reg;

    word_t im_w, ms_w, hdt_w, dt_w;
    logic  en;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_mass_reg  <= RST_INV_MASS;
            mass_reg      <= RST_MASS;
            half_step_reg <= RST_HALF_STEP;
            step_reg      <= RST_STEP;
            dims_reg      <= RST_DIMS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_INV_MASS:  inv_mass_reg  <= cfg_data[REG_BITS-1:0];
                CFG_MASS:      mass_reg      <= cfg_data[REG_BITS-1:0];
                CFG_HALF_STEP: half_step_reg <= cfg_data[REG_BITS-1:0];
                CFG_STEP:      step_reg      <= cfg_data[REG_BITS-1:0];
                CFG_DIMS:      dims_reg      <= cfg_data[1:0];
                default:       ;
            endcase
        end
    end

    assign im_w  = reg_word(inv_mass_reg);
    assign ms_w  = reg_word(mass_reg);
    assign hdt_w = reg_word(half_step_reg);
    assign dt_w  = reg_word(step_reg);

    // Global advance: only a held output result stops the pipe
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // Stage 1: charge * inverse mass, momentum * inverse mass
    logic  vld1_reg;
    word_t qim1_reg, qim1_next;
    vec_t  pim1_reg, pim1_next, e1_reg, e1_next, b1_reg, b1_next;

    always_comb
    begin
        word_t qw;
        qw = word_t'(in_data.particle_charge);
        qim1_next = smul_int(qw, im_w);
        pim1_next[0] = smul(in_data.mom_x, im_w);
        pim1_next[1] = smul(in_data.mom_y, im_w);
        pim1_next[2] = smul(in_data.mom_z, im_w);
        e1_next = {in_data.efield_z, in_data.efield_y, in_data.efield_x};
        b1_next = {in_data.bfield_z, in_data.bfield_y, in_data.bfield_x};
    end

    // Stage 2: alpha
    logic  vld2_reg;
    word_t alpha2_reg, alpha2_next;
    vec_t  pim2_reg, e2_reg, b2_reg;

    assign alpha2_next = smul(qim1_reg, hdt_w);

    // Stage 3: alpha * E and T = alpha * B
    logic vld3_reg;
    vec_t ae3_reg, ae3_next, t3_reg, t3_next, pim3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ae3_next[i] = smul(alpha2_reg, word_t'(e2_reg[i]));
            t3_next[i]  = smul(alpha2_reg, word_t'(b2_reg[i]));
        end
    end

    // Stage 4: u- and squares of T
    logic vld4_reg;
    vec_t um4_reg, um4_next, tt4_reg, tt4_next, t4_reg, ae4_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            um4_next[i] = sadd(word_t'(pim3_reg[i]), word_t'(ae3_reg[i]));
            tt4_next[i] = smul(word_t'(t3_reg[i]), word_t'(t3_reg[i]));
        end
    end

    // Stage 5: denominator and u- x T products
    logic  vld5_reg;
    word_t den5_reg, den5_next;
    vec_t  c1_5_reg, c1_5_next, c2_5_reg, c2_5_next, um5_reg, t5_reg, ae5_reg;

    always_comb
    begin
        int j;
        int k;
        den5_next = sadd(ONE, sadd(sadd(word_t'(tt4_reg[0]), word_t'(tt4_reg[1])),
                                   word_t'(tt4_reg[2])));
        for (int i = 0; i < 3; i++)
        begin
            j = (i == 2) ? 0 : i + 1;
            k = (i == 0) ? 2 : i - 1;
            c1_5_next[i] = smul(word_t'(um4_reg[j]), word_t'(t4_reg[k]));
            c2_5_next[i] = smul(word_t'(um4_reg[k]), word_t'(t4_reg[j]));
        end
    end

    // u' feeds the divider's side path
    side_t div_side;

    always_comb
    begin
        div_side.um = um5_reg;
        div_side.ae = ae5_reg;
        for (int i = 0; i < 3; i++)
            div_side.ur[i] = sadd(word_t'(um5_reg[i]),
                                  ssub(word_t'(c1_5_reg[i]), word_t'(c2_5_reg[i])));
    end

    logic  vldd;
    vec_t  sd;
    side_t sided;

    bpnr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vld5_reg),
        .in_tv    (t5_reg),
        .in_den   (den5_reg),
        .in_side  (div_side),
        .out_vld  (vldd),
        .out_s    (sd),
        .out_side (sided)
    );

    // Stage 7: u' x S products
    logic vld7_reg;
    vec_t d1_7_reg, d1_7_next, d2_7_reg, d2_7_next, um7_reg, ae7_reg;

    always_comb
    begin
        int j;
        int k;
        for (int i = 0; i < 3; i++)
        begin
            j = (i == 2) ? 0 : i + 1;
            k = (i == 0) ? 2 : i - 1;
            d1_7_next[i] = smul(word_t'(sided.ur[j]), word_t'(sd[k]));
            d2_7_next[i] = smul(word_t'(sided.ur[k]), word_t'(sd[j]));
        end
    end

    // Stage 8: u+ and the second half kick
    logic vld8_reg;
    vec_t v8_reg, v8_next;

    always_comb
    begin
        word_t up;
        for (int i = 0; i < 3; i++)
        begin
            up = sadd(word_t'(um7_reg[i]), ssub(word_t'(d1_7_reg[i]), word_t'(d2_7_reg[i])));
            v8_next[i] = sadd(up, word_t'(ae7_reg[i]));
        end
    end

    // Stage 9: scale by mass
    logic vld9_reg;
    vec_t np9_reg, np9_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            np9_next[i] = smul(ms_w, word_t'(v8_reg[i]));
    end

    // Stage 10: position increment, output register
    logic vld10_reg;
    vec_t np10_reg, ps10_reg, ps10_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            ps10_next[i] = (2'(i) < dims_reg) ? smul(dt_w, word_t'(np9_reg[i])) : '0;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg  <= 1'b0;
            vld2_reg  <= 1'b0;
            vld3_reg  <= 1'b0;
            vld4_reg  <= 1'b0;
            vld5_reg  <= 1'b0;
            vld7_reg  <= 1'b0;
            vld8_reg  <= 1'b0;
            vld9_reg  <= 1'b0;
            vld10_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg  <= in_valid;
            vld2_reg  <= vld1_reg;
            vld3_reg  <= vld2_reg;
            vld4_reg  <= vld3_reg;
            vld5_reg  <= vld4_reg;
            vld7_reg  <= vldd;
            vld8_reg  <= vld7_reg;
            vld9_reg  <= vld8_reg;
            vld10_reg <= vld9_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qim1_reg   <= qim1_next;
            pim1_reg   <= pim1_next;
            e1_reg     <= e1_next;
            b1_reg     <= b1_next;

            alpha2_reg <= alpha2_next;
            pim2_reg   <= pim1_reg;
            e2_reg     <= e1_reg;
            b2_reg     <= b1_reg;

            ae3_reg    <= ae3_next;
            t3_reg     <= t3_next;
            pim3_reg   <= pim2_reg;

            um4_reg    <= um4_next;
            tt4_reg    <= tt4_next;
            t4_reg     <= t3_reg;
            ae4_reg    <= ae3_reg;

            den5_reg   <= den5_next;
            c1_5_reg   <= c1_5_next;
            c2_5_reg   <= c2_5_next;
            um5_reg    <= um4_reg;
            t5_reg     <= t4_reg;
            ae5_reg    <= ae4_reg;

            d1_7_reg   <= d1_7_next;
            d2_7_reg   <= d2_7_next;
            um7_reg    <= sided.um;
            ae7_reg    <= sided.ae;

            v8_reg     <= v8_next;
            np9_reg    <= np9_next;

            np10_reg   <= np9_reg;
            ps10_reg   <= ps10_next;
        end
    end

    assign out_valid           = vld10_reg;
    assign out_data.new_mom_x  = word_t'(np10_reg[0]);
    assign out_data.new_mom_y  = word_t'(np10_reg[1]);
    assign out_data.new_mom_z  = word_t'(np10_reg[2]);
    assign out_data.pos_step_x = word_t'(ps10_reg[0]);
    assign out_data.pos_step_y = word_t'(ps10_reg[1]);
    assign out_data.pos_step_z = word_t'(ps10_reg[2]);

    // Upper bits of cfg_data are not stored
    logic unused_cfg;
    assign unused_cfg = ^cfg_data[CFG_BITS-1:REG_BITS];

endmodule

`default_nettype wire

// File: rtl/bpnr_div.sv
`default_nettype none

// Pipelined restoring divider, three lanes sharing one divisor:
// s = t * 2^(FRAC_BITS+1) / den, truncated toward zero and saturated.
// One quotient bit per stage, plus an entry and a fix-up register.
module bpnr_div
    import bpnr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_vld,
    input  wire vec_t  in_tv,
    input  wire word_t in_den,
    input  wire side_t in_side,
    output logic       out_vld,
    output vec_t       out_s,
    output side_t      out_side
);

    dvec_t lane_reg [0:QUO_BITS];
    dvec_t lane_next [1:QUO_BITS];
    word_t den_reg  [0:QUO_BITS];
    side_t side_reg [0:QUO_BITS];
    logic  vld_reg  [0:QUO_BITS];
    dvec_t lane0_next;
    vec_t  s_next;
    vec_t  s_reg;
    side_t side_out_reg;
    logic  vld_out_reg;

    // Entry: magnitude of t shifted up into the remainder
    always_comb
    begin
        logic [WORD_BITS-1:0] tu;
        logic [WORD_BITS-1:0] mg;
        for (int l = 0; l < 3; l++)
        begin
            tu = in_tv[l];
            mg = tu[WORD_BITS-1] ? (~tu + WORD_BITS'(1)) : tu;
            lane0_next[l].rem = REM_BITS'(mg) << (FRAC_BITS + 1);
            lane0_next[l].quo = '0;
            lane0_next[l].neg = tu[WORD_BITS-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg[0] <= lane0_next;
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 1; k <= QUO_BITS; k++)
    begin : g_stage
        localparam int BIT = QUO_BITS - k;

        always_comb
        begin
            logic [REM_BITS-1:0] dsh;
            dsh = REM_BITS'($unsigned(den_reg[k-1])) << BIT;
            for (int l = 0; l < 3; l++)
            begin
                lane_next[k][l] = lane_reg[k-1][l];
                if (lane_reg[k-1][l].rem >= dsh)
                begin
                    lane_next[k][l].rem      = lane_reg[k-1][l].rem - dsh;
                    lane_next[k][l].quo[BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lane_reg[k] <= lane_next[k];
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Sign and saturation fix-up
    always_comb
    begin
        for (int l = 0; l < 3; l++)
            s_next[l] = div_fix(lane_reg[QUO_BITS][l].neg, lane_reg[QUO_BITS][l].quo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_out_reg <= 1'b0;
        else if (en)
            vld_out_reg <= vld_reg[QUO_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg        <= s_next;
            side_out_reg <= side_reg[QUO_BITS];
        end
    end

    assign out_vld  = vld_out_reg;
    assign out_s    = s_reg;
    assign out_side = side_out_reg;

    // den of the last stage feeds no logic; keep it consumed
    logic unused_den;
    assign unused_den = ^den_reg[QUO_BITS];

endmodule

`default_nettype wire
